[rtl/core/mcg_pkg.sv]
// ----------------------------------------------------------------------------
// Month calendar grid package
// Types, control-word layout, microcode table and small arithmetic helpers
// shared by the sequencer, the datapath and the top level.
// ----------------------------------------------------------------------------
package mcg_pkg;

  localparam int YEAR_W  = 9;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int IDX_W   = 6;
  localparam int STEP_W  = 4;
  localparam int MOD7_W  = 3;

  localparam logic [IDX_W-1:0] GRID_SHORT = 6'd35;
  localparam logic [IDX_W-1:0] GRID_MID   = 6'd42;
  localparam logic [IDX_W-1:0] GRID_LONG  = 6'd49;

  // Column of 2000-01-01 (a Saturday) in a Monday-first week.
  localparam logic [MOD7_W-1:0] EPOCH_COLUMN = 3'd5;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  // Datapath operations selected by the control word.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_CHECK,
    OP_ADD_Y,
    OP_ADD_Q4,
    OP_ADD_Q100,
    OP_ADD_Q400,
    OP_ADD_DBM,
    OP_ADD_LEAP,
    OP_LENGTHS,
    OP_GRID,
    OP_EMIT,
    OP_EMIT_INV
  } mcg_op_t;

  // Jump conditions; the jump is taken when the condition holds.
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_BAD_MONTH,
    COND_OUT_WAIT,
    COND_CELLS_LEFT
  } mcg_cond_t;

  typedef struct packed {
    mcg_op_t             op;
    mcg_cond_t           cond;
    logic [STEP_W-1:0]   target;
    logic                in_ready;
    logic                out_valid;
  } mcg_ctl_t;

  // Status fed back from the datapath and the channels to the sequencer.
  typedef struct packed {
    logic in_valid;
    logic out_ready;
    logic bad_month;
    logic last;
  } mcg_flags_t;

  // Program addresses.
  localparam logic [STEP_W-1:0] STEP_WAIT    = 4'd0;
  localparam logic [STEP_W-1:0] STEP_EMIT    = 4'd10;
  localparam logic [STEP_W-1:0] STEP_INVALID = 4'd12;

  // Microcode: one control word per step.
  function automatic mcg_ctl_t mcg_ucode(input logic [STEP_W-1:0] step);
    mcg_ctl_t w;
    w = '{op: OP_NOP, cond: COND_ALWAYS, target: STEP_WAIT,
          in_ready: 1'b0, out_valid: 1'b0};
    case (step)
      4'd0: begin
        w.op = OP_LOAD; w.cond = COND_NO_INPUT; w.target = STEP_WAIT;
        w.in_ready = 1'b1;
      end
      4'd1: begin
        w.op = OP_CHECK; w.cond = COND_BAD_MONTH; w.target = STEP_INVALID;
      end
      4'd2: begin w.op = OP_ADD_Y;    w.cond = COND_NEVER; end
      4'd3: begin w.op = OP_ADD_Q4;   w.cond = COND_NEVER; end
      4'd4: begin w.op = OP_ADD_Q100; w.cond = COND_NEVER; end
      4'd5: begin w.op = OP_ADD_Q400; w.cond = COND_NEVER; end
      4'd6: begin w.op = OP_ADD_DBM;  w.cond = COND_NEVER; end
      4'd7: begin w.op = OP_ADD_LEAP; w.cond = COND_NEVER; end
      4'd8: begin w.op = OP_LENGTHS;  w.cond = COND_NEVER; end
      4'd9: begin w.op = OP_GRID;     w.cond = COND_NEVER; end
      4'd10: begin
        w.op = OP_EMIT; w.cond = COND_CELLS_LEFT; w.target = STEP_EMIT;
        w.out_valid = 1'b1;
      end
      4'd11: begin w.op = OP_NOP; w.cond = COND_ALWAYS; w.target = STEP_WAIT; end
      4'd12: begin
        w.op = OP_EMIT_INV; w.cond = COND_OUT_WAIT; w.target = STEP_INVALID;
        w.out_valid = 1'b1;
      end
      default: begin
        w.op = OP_NOP; w.cond = COND_ALWAYS; w.target = STEP_WAIT;
      end
    endcase
    return w;
  endfunction

  // Days before each month, reduced modulo 7 (indexed by month number).
  function automatic logic [MOD7_W-1:0] mcg_dbm_mod7(input logic [MONTH_W-1:0] m);
    logic [MOD7_W-1:0] r;
    case (m)
      4'd1:    r = 3'd0;
      4'd2:    r = 3'd3;
      4'd3:    r = 3'd3;
      4'd4:    r = 3'd6;
      4'd5:    r = 3'd1;
      4'd6:    r = 3'd4;
      4'd7:    r = 3'd6;
      4'd8:    r = 3'd2;
      4'd9:    r = 3'd5;
      4'd10:   r = 3'd0;
      4'd11:   r = 3'd3;
      4'd12:   r = 3'd5;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  // Length of a month; anything but February and the short months has 31.
  function automatic logic [DAY_W-1:0] mcg_month_days(input logic [MONTH_W-1:0] m,
                                                      input logic leap);
    logic [DAY_W-1:0] r;
    case (m)
      4'd2:    r = leap ? 5'd29 : 5'd28;
      4'd4:    r = 5'd30;
      4'd6:    r = 5'd30;
      4'd9:    r = 5'd30;
      4'd11:   r = 5'd30;
      default: r = 5'd31;
    endcase
    return r;
  endfunction

  // Residue modulo 7 of a 10-bit value: octal digits fold because 8 = 1 mod 7.
  function automatic logic [MOD7_W-1:0] mcg_mod7(input logic [9:0] x);
    logic [4:0] s1;
    logic [3:0] s2;
    logic [3:0] s3;
    s1 = 5'(x[9]) + 5'(x[8:6]) + 5'(x[5:3]) + 5'(x[2:0]);
    s2 = 4'(s1[4:3]) + 4'(s1[2:0]);
    s3 = 4'(s2[3]) + 4'(s2[2:0]);
    if (s3 >= 4'd7) begin
      s3 = s3 - 4'd7;
    end
    return s3[2:0];
  endfunction

endpackage

[rtl/core/mcg_ifs.sv]
// ----------------------------------------------------------------------------
// Month calendar grid channels
// Valid/ready channels for month requests and for grid cell results.
// ----------------------------------------------------------------------------
interface mcg_req_if;
  logic       valid;
  logic       ready;
  logic [8:0] year_offset;
  logic [3:0] month;

  modport source (output valid, output year_offset, output month, input ready);
  modport sink   (input valid, input year_offset, input month, output ready);
endinterface

interface mcg_cell_if;
  logic       valid;
  logic       ready;
  logic [4:0] day_number;
  logic [5:0] cell_index;
  logic       last_cell;
  logic       status;

  modport source (output valid, output day_number, output cell_index,
                  output last_cell, output status, input ready);
  modport sink   (input valid, input day_number, input cell_index,
                  input last_cell, input status, output ready);
endinterface

[rtl/core/month_calendar_grid_generator_unit.sv]
// ----------------------------------------------------------------------------
// Month calendar grid generator
// Emits the Monday-first month view for a year offset and month, one cell
// per beat, padded with the neighbouring months to 35, 42 or 49 cells (at most GRID_CELLS_MAX).
// ----------------------------------------------------------------------------
// Sequence: after the request beat, nine microcode steps check the month and
//   work out the weekday, month lengths and grid size before the first cell.
// Throughput: one cell per cycle while the sink is ready. A new request is
//   taken only when the previous grid or invalid-month cell is fully taken.
// Reset: synchronous, active high; the step counter returns to the wait step.
module month_calendar_grid_generator_unit #(
  parameter int GRID_CELLS_MAX = 49
) (
  input  logic            clk,
  input  logic            rst,
  mcg_req_if.sink         req,
  mcg_cell_if.source      cells
);
  import mcg_pkg::*;

  mcg_ctl_t   ctl;
  mcg_flags_t flags;
  logic       bad_month;
  logic       in_fire;
  logic       out_fire;

  // Handshake beats.
  assign req.ready   = ctl.in_ready;
  assign cells.valid = ctl.out_valid;
  assign in_fire     = req.valid && ctl.in_ready;
  assign out_fire    = cells.ready && ctl.out_valid;

  // Status back to the sequencer.
  assign flags = '{in_valid: req.valid, out_ready: cells.ready,
                   bad_month: bad_month, last: cells.last_cell};

  mcg_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctl   (ctl)
  );

  mcg_datapath #(
    .GRID_CELLS_MAX (GRID_CELLS_MAX)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .in_fire    (in_fire),
    .out_fire   (out_fire),
    .year_in    (req.year_offset),
    .month_in   (req.month),
    .bad_month  (bad_month),
    .day_number (cells.day_number),
    .cell_index (cells.cell_index),
    .last_cell  (cells.last_cell),
    .status     (cells.status)
  );

endmodule

[rtl/core/mcg_sequencer.sv]
// ----------------------------------------------------------------------------
// Month calendar grid sequencer
// Step counter over the microcode table with conditional jumps.
// ----------------------------------------------------------------------------
module mcg_sequencer (
  input  logic               clk,
  input  logic               rst,
  input  mcg_pkg::mcg_flags_t flags,
  output mcg_pkg::mcg_ctl_t   ctl
);
  import mcg_pkg::*;

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic              take_jump;

  // Control word for the current step.
  assign ctl = mcg_ucode(step);

  // Evaluate the jump condition of the current word.
  always_comb begin
    case (ctl.cond)
      COND_NEVER:      take_jump = 1'b0;
      COND_ALWAYS:     take_jump = 1'b1;
      COND_NO_INPUT:   take_jump = !flags.in_valid;
      COND_BAD_MONTH:  take_jump = flags.bad_month;
      COND_OUT_WAIT:   take_jump = !flags.out_ready;
      COND_CELLS_LEFT: take_jump = !(flags.out_ready && flags.last);
      default:         take_jump = 1'b1;
    endcase
    step_next = take_jump ? ctl.target : step + 1'b1;
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_WAIT;
    end else begin
      step <= step_next;
    end
  end

  // A step never both takes a request and offers a cell.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(ctl.in_ready && ctl.out_valid))
    else $error("sequencer offers a cell while taking a request");

  // The final cell of a grid being taken returns the program to the wait step.
  a_back_to_wait: assert property (@(posedge clk) disable iff (rst)
    (ctl.op == OP_EMIT && flags.out_ready && flags.last) |=> ##1 ctl.in_ready)
    else $error("sequencer did not return to wait after the final cell");

endmodule

[rtl/core/mcg_datapath.sv]
// ----------------------------------------------------------------------------
// Month calendar grid datapath
// Weekday accumulator modulo 7, month lengths and the cell output registers.
// ----------------------------------------------------------------------------
module mcg_datapath #(
  parameter int GRID_CELLS_MAX = 49
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mcg_pkg::mcg_ctl_t              ctl,
  input  logic                          in_fire,
  input  logic                          out_fire,
  input  logic [mcg_pkg::YEAR_W-1:0]    year_in,
  input  logic [mcg_pkg::MONTH_W-1:0]   month_in,
  output logic                          bad_month,
  output logic [mcg_pkg::DAY_W-1:0]     day_number,
  output logic [mcg_pkg::IDX_W-1:0]     cell_index,
  output logic                          last_cell,
  output logic                          status
);
  import mcg_pkg::*;

  localparam logic [IDX_W-1:0] GRID_CAP = IDX_W'(GRID_CELLS_MAX);

  logic [YEAR_W-1:0]  year;
  logic [MONTH_W-1:0] month;
  logic [MOD7_W-1:0]  acc;
  logic [MOD7_W-1:0]  start_column;
  logic [DAY_W-1:0]   this_month_length;
  logic [DAY_W-1:0]   prev_month_length;
  logic [IDX_W-1:0]   grid_length;
  logic [IDX_W-1:0]   month_end;

  logic               is_leap;
  logic               hundred;
  logic               four_hundred;
  logic [2:0]         q100;
  logic [1:0]         q400;
  logic [7:0]         q4;
  logic [YEAR_W-1:0]  term;
  logic [MOD7_W-1:0]  acc_sum;
  logic [IDX_W-1:0]   n_cells;
  logic [IDX_W-1:0]   grid_pick;
  logic [IDX_W-1:0]   idx_inc;
  logic [IDX_W-1:0]   idx_inc2;

  // Calendar facts about the latched year and month by small compares; q4 by an add and a shift.
  always_comb begin
    hundred = (year == 9'd0) || (year == 9'd100) || (year == 9'd200) ||
              (year == 9'd300) || (year == 9'd400) || (year == 9'd500);
    four_hundred = (year == 9'd0) || (year == 9'd400);
    is_leap = (year[1:0] == 2'b00) && (!hundred || four_hundred);
    q100 = 3'(year >= 9'd1) + 3'(year >= 9'd101) + 3'(year >= 9'd201) +
           3'(year >= 9'd301) + 3'(year >= 9'd401) + 3'(year >= 9'd501);
    q400 = 2'(year >= 9'd1) + 2'(year >= 9'd401);
    q4   = 8'((10'(year) + 10'd3) >> 2);
    bad_month = (month < MONTH_JAN) || (month > MONTH_DEC);
  end

  // Term added to the weekday accumulator by the current operation.
  always_comb begin
    case (ctl.op)
      OP_ADD_Y:    term = year;
      OP_ADD_Q4:   term = 9'(q4);
      OP_ADD_Q100: term = 9'(3'd7 - q100);
      OP_ADD_Q400: term = 9'(q400);
      OP_ADD_DBM:  term = 9'(mcg_dbm_mod7(month));
      OP_ADD_LEAP: term = 9'((month > MONTH_FEB) && is_leap);
      default:     term = '0;
    endcase
    acc_sum = mcg_mod7(10'(acc) + 10'(term));
  end

  // Grid size from the column of day 1 and the month length.
  always_comb begin
    n_cells = IDX_W'(start_column) + IDX_W'(this_month_length);
    if (n_cells <= GRID_SHORT) begin
      grid_pick = GRID_SHORT;
    end else if (n_cells <= GRID_MID) begin
      grid_pick = GRID_MID;
    end else begin
      grid_pick = GRID_LONG;
    end
    if (grid_pick > GRID_CAP) begin
      grid_pick = GRID_CAP;
    end
    idx_inc  = cell_index + 1'b1;
    idx_inc2 = cell_index + 6'd2;
  end

  // Operand and accumulator registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc               <= '0;
      start_column      <= '0;
      this_month_length <= '0;
      prev_month_length <= '0;
      grid_length       <= '0;
      month_end         <= '0;
    end else begin
      case (ctl.op)
        OP_LOAD: begin
          acc <= EPOCH_COLUMN;
        end
        OP_ADD_Y, OP_ADD_Q4, OP_ADD_Q100, OP_ADD_Q400, OP_ADD_DBM,
        OP_ADD_LEAP: begin
          acc <= acc_sum;
        end
        OP_LENGTHS: begin
          start_column      <= acc;
          this_month_length <= mcg_month_days(month, is_leap);
          prev_month_length <= (month == MONTH_JAN) ? 5'd31 :
                               mcg_month_days(month - 1'b1, is_leap);
        end
        OP_GRID: begin
          grid_length <= grid_pick;
          month_end   <= n_cells;
        end
        default: begin
        end
      endcase
    end
  end

  // Request latch and cell output registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      year  <= year_in;
      month <= month_in;
    end
    case (ctl.op)
      OP_CHECK: begin
        day_number <= '0;
        cell_index <= '0;
        last_cell  <= 1'b1;
        status     <= 1'b1;
      end
      OP_GRID: begin
        day_number <= (start_column == '0) ? 5'd1 :
                      prev_month_length - 5'(start_column) + 5'd1;
        cell_index <= '0;
        last_cell  <= 1'b0;
        status     <= 1'b0;
      end
      OP_EMIT: begin
        if (out_fire && !last_cell) begin
          cell_index <= idx_inc;
          last_cell  <= (idx_inc2 == grid_length);
          if ((idx_inc == IDX_W'(start_column)) || (idx_inc == month_end)) begin
            day_number <= 5'd1;
          end else begin
            day_number <= day_number + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Cells of a grid stay within its length.
  a_idx_in_grid: assert property (@(posedge clk) disable iff (rst)
    (ctl.op == OP_EMIT) |-> (cell_index < grid_length))
    else $error("cell index beyond grid length");

  // The final-cell flag marks exactly the last position of the grid.
  a_last_matches: assert property (@(posedge clk) disable iff (rst)
    (ctl.op == OP_EMIT) |-> (last_cell == (idx_inc == grid_length)))
    else $error("final-cell flag out of step with cell index");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Month calendar grid generator testbench
// Sends month requests through the request channel and checks every grid
// cell against an in-bench calendar predictor. Idle and stall patterns on
// both channels change from phase to phase, ending with both sides at full
// rate.
// ----------------------------------------------------------------------------
module tb_top;
  import mcg_pkg::*;

  localparam int GRID_LIMIT   = 49;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int YEAR_TOP     = 511;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_BAD_MONTH = 1'b1;

  // One grid cell as it leaves the block.
  typedef struct packed {
    logic [DAY_W-1:0] day;
    logic [IDX_W-1:0] idx;
    logic             last;
    logic             status;
  } grid_cell_t;

  // Calendar predictor and store of the cells still owed by the block.
  class grid_scoreboard;
    grid_cell_t  pending_cells[$];
    int unsigned mismatches;
    int unsigned first_column;
    int unsigned cur_len;
    int unsigned prev_len;
    int unsigned grid_len;

    function new();
      mismatches   = 0;
      first_column = 0;
      cur_len      = 0;
      prev_len     = 0;
      grid_len     = 0;
    endfunction

    function bit leap_year(int unsigned y);
      return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    endfunction

    function int unsigned month_len(int unsigned y, int unsigned m);
      case (m)
        2: return leap_year(y) ? 29 : 28;
        4, 6, 9, 11: return 30;
        default: return 31;
      endcase
    endfunction

    // Works out the whole grid for one accepted request.
    function void add_request(logic [YEAR_W-1:0] year, logic [MONTH_W-1:0] month);
      int unsigned y;
      int unsigned m;
      int unsigned days;
      int unsigned fill_end;
      int unsigned day;
      grid_cell_t  exp_cell;
      y = year;
      m = month;
      // A month outside the calendar gives a single flagged cell and
      // leaves the calendar state alone.
      if (month < MONTH_JAN || month > MONTH_DEC) begin
        exp_cell = '{day: '0, idx: '0, last: 1'b1, status: STATUS_BAD_MONTH};
        pending_cells.push_back(exp_cell);
        return;
      end
      // Days from the epoch Saturday to the first of the month.
      days = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
      for (int unsigned k = 1; k < m; k++) begin
        days += month_len(y, k);
      end
      first_column = (EPOCH_COLUMN + days) % 7;
      cur_len      = month_len(y, m);
      prev_len     = (month == MONTH_JAN) ? 31 : month_len(y, m - 1);
      fill_end     = first_column + cur_len;
      if (fill_end <= GRID_SHORT) begin
        grid_len = GRID_SHORT;
      end else if (fill_end <= GRID_MID) begin
        grid_len = GRID_MID;
      end else begin
        grid_len = GRID_LONG;
      end
      if (grid_len > GRID_LIMIT) begin
        grid_len = GRID_LIMIT;
      end
      for (int unsigned k = 0; k < grid_len; k++) begin
        if (k < first_column) begin
          day = prev_len - (first_column - 1 - k);
        end else if (k < fill_end) begin
          day = k - first_column + 1;
        end else begin
          day = k - fill_end + 1;
        end
        exp_cell.day    = day[DAY_W-1:0];
        exp_cell.idx    = k[IDX_W-1:0];
        exp_cell.last   = (k + 1 == grid_len);
        exp_cell.status = STATUS_OK;
        pending_cells.push_back(exp_cell);
      end
    endfunction

    function void compare_field(string label, int unsigned want, int unsigned got);
      if (want != got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
      end
    endfunction

    // Checks one cell beat against the oldest expected cell.
    function void check_cell(grid_cell_t got);
      grid_cell_t want;
      if (pending_cells.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected cell, expected none, actual day %0d index %0d",
                 $time, got.day, got.idx);
        return;
      end
      want = pending_cells.pop_front();
      compare_field("day_number", want.day, got.day);
      compare_field("cell_index", want.idx, got.idx);
      compare_field("last_cell", want.last, got.last);
      compare_field("status", want.status, got.status);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  grid_scoreboard sb;

  mcg_req_if  req_ch();
  mcg_cell_if cell_ch();

  month_calendar_grid_generator_unit #(
    .GRID_CELLS_MAX(GRID_LIMIT)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .req   (req_ch),
    .cells (cell_ch)
  );

  always #2 clk = ~clk;

  // Run guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Cell sink: checks each accepted beat and stalls at random.
  always @(posedge clk) begin
    if (rst) begin
      cell_ch.ready <= 1'b0;
    end else begin
      if (cell_ch.valid && cell_ch.ready) begin
        sb.check_cell('{day: cell_ch.day_number, idx: cell_ch.cell_index,
                        last: cell_ch.last_cell, status: cell_ch.status});
      end
      cell_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offers one request, with random idle cycles ahead of it, and notes it
  // once the beat is taken.
  task automatic send_month_request(input logic [YEAR_W-1:0] year,
                                    input logic [MONTH_W-1:0] month);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.year_offset <= year;
    req_ch.month       <= month;
    do begin
      @(posedge clk);
    end while (!req_ch.ready);
    sb.add_request(year, month);
  endtask

  // Mostly real months over the whole year range, with some centuries and
  // some months that do not exist.
  task automatic random_requests(input int count);
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0) begin
        year = YEAR_W'(100 * $urandom_range(5));
      end else begin
        year = YEAR_W'($urandom_range(YEAR_TOP));
      end
      if ($urandom_range(99) < 85) begin
        month = MONTH_W'($urandom_range(12, 1));
      end else begin
        month = MONTH_W'($urandom_range(3));
        if (month != 0) begin
          month = month + MONTH_DEC;
        end
      end
      send_month_request(year, month);
    end
  endtask

  initial begin
    sb = new();
    rst                <= 1'b1;
    req_ch.valid       <= 1'b0;
    req_ch.year_offset <= '0;
    req_ch.month       <= '0;
    send_idle_pct = 23;
    recv_idle_pct = 69;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part: epoch month, leap rules, neighbouring-month padding,
    // year offsets past 399 and months that do not exist.
    send_month_request(9'd0, MONTH_JAN);
    send_month_request(9'd0, MONTH_FEB);
    send_month_request(9'd0, 4'd3);
    send_month_request(9'd1, MONTH_FEB);
    send_month_request(9'd4, MONTH_FEB);
    send_month_request(9'd100, MONTH_FEB);
    send_month_request(9'd400, MONTH_FEB);
    send_month_request(9'd500, MONTH_FEB);
    send_month_request(9'd21, MONTH_FEB);
    send_month_request(9'd15, MONTH_FEB);
    send_month_request(9'd10, 4'd5);
    send_month_request(9'd20, 4'd8);
    send_month_request(9'd23, 4'd4);
    send_month_request(9'd24, 4'd6);
    send_month_request(9'd99, MONTH_DEC);
    send_month_request(9'd399, MONTH_DEC);
    send_month_request(9'd511, MONTH_JAN);
    send_month_request(9'd511, MONTH_DEC);
    send_month_request(9'd256, 4'd11);
    send_month_request(9'd0, 4'd0);
    send_month_request(9'd511, 4'd13);
    send_month_request(9'd170, 4'd15);
    send_month_request(9'd341, 4'd14);
    send_month_request(9'd342, 4'd9);
    send_month_request(9'd123, 4'd10);

    // Random part in three idling phases.
    random_requests(35);
    send_idle_pct = 69;
    recv_idle_pct = 23;
    random_requests(35);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_requests(35);
    req_ch.valid <= 1'b0;

    // Drain, then give the block time to show any stray beat.
    while (sb.pending_cells.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending_cells.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
